// File: rtl/core/two_reservoir_discharge_step_defines.svh
// assertion macros used by the checker in trds_checker.sv
`ifndef TWO_RESERVOIR_DISCHARGE_STEP_DEFINES_SVH
`define TWO_RESERVOIR_DISCHARGE_STEP_DEFINES_SVH

// same-cycle implication, held off during reset
`define TRDS_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TRDS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: rtl/core/trds_pkg.sv
package trds_pkg;

    localparam int LEVEL_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int TAG_W     = 16;
    localparam int DIS_W     = 33;
    localparam int PROD_W    = LEVEL_W + GAIN_W;
    localparam int IN_W      = 80;
    localparam int OUT_W     = 120;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PIPE_DEPTH = 8;
    localparam int DEFAULT_FRAC_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURFACE_THRESHOLD  = 3'd0,
        REG_SURFACE_GAIN       = 3'd1,
        REG_INTERFLOW_GAIN     = 3'd2,
        REG_BASEFLOW_GAIN      = 3'd3,
        REG_PERCOLATION_AMOUNT = 3'd4
    } cfg_reg_t;

endpackage

// File: rtl/core/two_reservoir_discharge_step.sv
// an input transaction passes through the stage registers 1 to 8 to m_tdata
// throughput: one cell per cycle while the output is not stalled, set by the
// eight-stage pipeline with one 32x16 multiplier in each of stages 2, 4 and 7
// a stalled output holds each full stage with no empty stage after it; the rest keep moving
// reset clears all valid bits and the configuration registers to zero
module two_reservoir_discharge_step
    import trds_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cell_index[15:0], upper_level[47:16], lower_level[79:48]
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cell_tag[15:0], new_upper_level[47:16], new_lower_level[79:48],
    // total_discharge[112:80], zero fill above
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // (amount * gain) >> FRAC_BITS, capped at amount
    function automatic logic [LEVEL_W-1:0] cap_flow(input logic [PROD_W-1:0] prod,
                                                   input logic [LEVEL_W-1:0] amount);
        logic [PROD_W-1:0] q;
        q = prod >> FRAC_BITS;
        if (q > PROD_W'(amount))
        begin
            return amount;
        end
        return q[LEVEL_W-1:0];
    endfunction

    // configuration
    logic [LEVEL_W-1:0] thr_reg, thr_next;
    logic [GAIN_W-1:0]  sgain_reg, sgain_next;
    logic [GAIN_W-1:0]  igain_reg, igain_next;
    logic [GAIN_W-1:0]  bgain_reg, bgain_next;
    logic [LEVEL_W-1:0] perc_reg, perc_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next   = thr_reg;
        sgain_next = sgain_reg;
        igain_next = igain_reg;
        bgain_next = bgain_reg;
        perc_next  = perc_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SURFACE_THRESHOLD:  thr_next   = cfg_data[LEVEL_W-1:0];
                REG_SURFACE_GAIN:       sgain_next = cfg_data[GAIN_W-1:0];
                REG_INTERFLOW_GAIN:     igain_next = cfg_data[GAIN_W-1:0];
                REG_BASEFLOW_GAIN:      bgain_next = cfg_data[GAIN_W-1:0];
                REG_PERCOLATION_AMOUNT: perc_next  = cfg_data[LEVEL_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            sgain_reg <= '0;
            igain_reg <= '0;
            bgain_reg <= '0;
            perc_reg  <= '0;
        end
        else
        begin
            thr_reg   <= thr_next;
            sgain_reg <= sgain_next;
            igain_reg <= igain_next;
            bgain_reg <= bgain_next;
            perc_reg  <= perc_next;
        end
    end

    // pipeline control: a stage loads when empty or when the next one moves
    logic [PIPE_DEPTH:1] v_reg, v_next;
    logic [PIPE_DEPTH+1:1] en;

    always_comb
    begin
        en[PIPE_DEPTH+1] = m_tready;
        for (int k = PIPE_DEPTH; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[1])
        begin
            v_next[1] = s_tvalid;
        end
        for (int k = 2; k <= PIPE_DEPTH; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[PIPE_DEPTH];

    // input fields
    logic [TAG_W-1:0]   in_tag;
    logic [LEVEL_W-1:0] in_upper;
    logic [LEVEL_W-1:0] in_lower;
    logic [LEVEL_W:0]   in_diff;

    assign in_tag   = s_tdata[TAG_W-1:0];
    assign in_upper = s_tdata[TAG_W+LEVEL_W-1:TAG_W];
    assign in_lower = s_tdata[TAG_W+2*LEVEL_W-1:TAG_W+LEVEL_W];
    assign in_diff  = {1'b0, in_upper} - {1'b0, thr_reg};

    // stage payloads
    logic [TAG_W-1:0]   tag_reg [1:PIPE_DEPTH];
    logic [LEVEL_W-1:0] ex1_reg, up1_reg, lo1_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [LEVEL_W-1:0] ex2_reg, up2_reg, lo2_reg;
    logic [LEVEL_W-1:0] qs3_reg, up3_reg, lo3_reg;
    logic [PROD_W-1:0]  prod4_reg;
    logic [LEVEL_W-1:0] qs4_reg, up4_reg, lo4_reg;
    logic [DIS_W-1:0]   qsi5_reg;
    logic [LEVEL_W-1:0] up5_reg, lo5_reg;
    logic [DIS_W-1:0]   qsi6_reg;
    logic [LEVEL_W-1:0] up6_reg, lo6_reg;
    logic [PROD_W-1:0]  prod7_reg;
    logic [DIS_W-1:0]   qsi7_reg;
    logic [LEVEL_W-1:0] up7_reg, lo7_reg;
    logic [DIS_W-1:0]   dis8_reg;
    logic [LEVEL_W-1:0] up8_reg, lo8_reg;

    // combinational helpers
    logic [LEVEL_W-1:0] qs3_next;
    logic [LEVEL_W-1:0] qi5_next;
    logic [LEVEL_W:0]   perc_diff;
    logic [LEVEL_W-1:0] moved6;
    logic [LEVEL_W:0]   lo_sum6;
    logic [LEVEL_W-1:0] qb8_next;

    assign qs3_next  = cap_flow(prod2_reg, ex2_reg);
    assign qi5_next  = cap_flow(prod4_reg, up4_reg);
    assign perc_diff = {1'b0, up5_reg} - {1'b0, perc_reg};
    // upper above percolation amount moves the amount, else all of upper
    assign moved6    = perc_diff[LEVEL_W] || (perc_diff == '0) ? up5_reg : perc_reg;
    assign lo_sum6   = {1'b0, lo5_reg} + {1'b0, moved6};
    assign qb8_next  = cap_flow(prod7_reg, lo7_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tag_reg[1] <= in_tag;
            ex1_reg    <= in_diff[LEVEL_W] ? '0 : in_diff[LEVEL_W-1:0];
            up1_reg    <= in_upper;
            lo1_reg    <= in_lower;
        end
        if (en[2])
        begin
            tag_reg[2] <= tag_reg[1];
            prod2_reg  <= PROD_W'(ex1_reg) * PROD_W'(sgain_reg);
            ex2_reg    <= ex1_reg;
            up2_reg    <= up1_reg;
            lo2_reg    <= lo1_reg;
        end
        if (en[3])
        begin
            tag_reg[3] <= tag_reg[2];
            qs3_reg    <= qs3_next;
            up3_reg    <= up2_reg - qs3_next;
            lo3_reg    <= lo2_reg;
        end
        if (en[4])
        begin
            tag_reg[4] <= tag_reg[3];
            prod4_reg  <= PROD_W'(up3_reg) * PROD_W'(igain_reg);
            qs4_reg    <= qs3_reg;
            up4_reg    <= up3_reg;
            lo4_reg    <= lo3_reg;
        end
        if (en[5])
        begin
            tag_reg[5] <= tag_reg[4];
            qsi5_reg   <= DIS_W'(qs4_reg) + DIS_W'(qi5_next);
            up5_reg    <= up4_reg - qi5_next;
            lo5_reg    <= lo4_reg;
        end
        if (en[6])
        begin
            tag_reg[6] <= tag_reg[5];
            qsi6_reg   <= qsi5_reg;
            up6_reg    <= up5_reg - moved6;
            lo6_reg    <= lo_sum6[LEVEL_W] ? '1 : lo_sum6[LEVEL_W-1:0];
        end
        if (en[7])
        begin
            tag_reg[7] <= tag_reg[6];
            prod7_reg  <= PROD_W'(lo6_reg) * PROD_W'(bgain_reg);
            qsi7_reg   <= qsi6_reg;
            up7_reg    <= up6_reg;
            lo7_reg    <= lo6_reg;
        end
        if (en[8])
        begin
            tag_reg[8] <= tag_reg[7];
            dis8_reg   <= qsi7_reg + DIS_W'(qb8_next);
            up8_reg    <= up7_reg;
            lo8_reg    <= lo7_reg - qb8_next;
        end
    end

    assign m_tdata = {(OUT_W - TAG_W - 2*LEVEL_W - DIS_W)'(0),
                      dis8_reg, lo8_reg, up8_reg, tag_reg[PIPE_DEPTH]};

endmodule

// File: rtl/core/trds_checker.sv
`include "two_reservoir_discharge_step_defines.svh"

module trds_checker
    import trds_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // items accepted but not yet delivered
    logic [CNT_W-1:0] open_reg, open_next;
    logic             in_fire, out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_comb
    begin
        open_next = open_reg;
        if (in_fire && !out_fire)
        begin
            open_next = open_reg + CNT_W'(1);
        end
        else if (out_fire && !in_fire)
        begin
            open_next = open_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `TRDS_ASSERT_NOW(a_no_invented_result, clk, rst_n, m_tvalid, open_reg != '0, "result without a pending input transaction")
    `TRDS_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1, open_reg <= CNT_W'(PIPE_DEPTH), "more items in flight than pipeline stages")
    `TRDS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, open_reg == '0, s_tready, "empty pipeline refuses input")
    `TRDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed or dropped")

endmodule

bind two_reservoir_discharge_step trds_checker u_trds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/two_reservoir_discharge_step_checker.sv
`timescale 1ns / 100ps

module two_reservoir_discharge_step_checker
    import trds_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   in_flight,
    output int                   results_checked
);

    // packed so that it lines up with m_tdata from bit 0
    typedef struct packed {
        logic [DIS_W-1:0]   discharge;
        logic [LEVEL_W-1:0] lower;
        logic [LEVEL_W-1:0] upper;
        logic [TAG_W-1:0]   tag;
    } cell_state_t;

    logic [LEVEL_W-1:0] threshold      = '0;
    logic [GAIN_W-1:0]  surface_gain   = '0;
    logic [GAIN_W-1:0]  interflow_gain = '0;
    logic [GAIN_W-1:0]  baseflow_gain  = '0;
    logic [LEVEL_W-1:0] percolation    = '0;

    cell_state_t expected_cells[$];
    int mismatches = 0;
    int pending    = 0;
    int checked    = 0;

    assign fail_count      = mismatches;
    assign in_flight       = pending;
    assign results_checked = checked;

    // truncated fraction of a store, never more than the store holds
    function automatic logic [LEVEL_W-1:0] recession(input logic [LEVEL_W-1:0] amount,
                                                     input logic [GAIN_W-1:0]  gain);
        logic [PROD_W-1:0] flow;
        flow = (PROD_W'(amount) * PROD_W'(gain)) >> FRAC_BITS;
        return (flow > PROD_W'(amount)) ? amount : flow[LEVEL_W-1:0];
    endfunction

    function automatic cell_state_t step_cell(input logic [IN_W-1:0] item);
        logic [LEVEL_W-1:0] upper;
        logic [LEVEL_W-1:0] lower;
        logic [LEVEL_W-1:0] moved;
        logic [LEVEL_W-1:0] q_surface;
        logic [LEVEL_W-1:0] q_inter;
        logic [LEVEL_W-1:0] q_base;
        logic [LEVEL_W:0]   filled;
        cell_state_t        res;
        upper     = item[TAG_W +: LEVEL_W];
        lower     = item[TAG_W + LEVEL_W +: LEVEL_W];
        q_surface = '0;
        q_inter   = '0;
        q_base    = '0;
        if (upper > threshold)
        begin
            q_surface = recession(upper - threshold, surface_gain);
            upper     = upper - q_surface;
        end
        if (upper != '0)
        begin
            q_inter = recession(upper, interflow_gain);
            upper   = upper - q_inter;
        end
        if (upper > percolation)
        begin
            moved = percolation;
            upper = upper - percolation;
        end
        else
        begin
            moved = upper;
            upper = '0;
        end
        // lower store saturates before base flow is drawn
        filled = {1'b0, lower} + {1'b0, moved};
        lower  = filled[LEVEL_W] ? '1 : filled[LEVEL_W-1:0];
        if (lower != '0)
        begin
            q_base = recession(lower, baseflow_gain);
            lower  = lower - q_base;
        end
        res.tag       = item[TAG_W-1:0];
        res.upper     = upper;
        res.lower     = lower;
        res.discharge = DIS_W'(q_surface) + DIS_W'(q_inter) + DIS_W'(q_base);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [DIS_W-1:0] want,
                               input logic [DIS_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : track
        cell_state_t want;
        cell_state_t got;
        int          change;
        change = 0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SURFACE_THRESHOLD:  threshold      = cfg_data;
                    REG_SURFACE_GAIN:       surface_gain   = cfg_data[GAIN_W-1:0];
                    REG_INTERFLOW_GAIN:     interflow_gain = cfg_data[GAIN_W-1:0];
                    REG_BASEFLOW_GAIN:      baseflow_gain  = cfg_data[GAIN_W-1:0];
                    REG_PERCOLATION_AMOUNT: percolation    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_cells.push_back(step_cell(s_tdata));
                change++;
            end
            if (m_tvalid && m_tready)
            begin
                got = cell_state_t'(m_tdata[$bits(cell_state_t)-1:0]);
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transaction with no cell waiting, expected none, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    change--;
                    checked++;
                    check_field("cell_tag", DIS_W'(want.tag), DIS_W'(got.tag));
                    check_field("new_upper_level", DIS_W'(want.upper), DIS_W'(got.upper));
                    check_field("new_lower_level", DIS_W'(want.lower), DIS_W'(got.lower));
                    check_field("total_discharge", want.discharge, got.discharge);
                end
            end
        end
        pending <= pending + change;
    end

endmodule

// File: tb/tb_two_reservoir_discharge_step.sv
`timescale 1ns / 100ps

module tb_two_reservoir_discharge_step;
    import trds_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int CELLS_PER_PHASE = 116;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [LEVEL_W-1:0] ONE_MM    = 32'h0001_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int fail_count;
    int in_flight;
    int results_checked;
    int cells_sent    = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;
    bit sender_busy   = 1'b0;
    bit sink_busy     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    two_reservoir_discharge_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    two_reservoir_discharge_step_checker #(
        .FRAC_BITS (DEFAULT_FRAC_BITS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .in_flight       (in_flight),
        .results_checked (results_checked)
    );

    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LEVEL_MAX;
            2:       return LEVEL_W'($urandom_range(0, 32'h0010_0000));
            default: return LEVEL_W'($urandom >> $urandom_range(0, 16));
        endcase
    endfunction

    // anchor is a boundary worth hitting: the threshold, or where lower saturates
    function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] anchor);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEVEL_MAX;
            2:       return anchor;
            3:       return anchor + LEVEL_W'($urandom_range(0, 255)) - 32'd128;
            4:       return LEVEL_MAX - LEVEL_W'($urandom_range(0, 32'h0010_0000));
            5:       return LEVEL_W'($urandom_range(0, 32'h0010_0000));
            default: return LEVEL_W'($urandom >> $urandom_range(0, 8));
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [LEVEL_W-1:0] threshold,
                                 input logic [GAIN_W-1:0]  s_gain,
                                 input logic [GAIN_W-1:0]  i_gain,
                                 input logic [GAIN_W-1:0]  b_gain,
                                 input logic [LEVEL_W-1:0] perc);
        write_reg(REG_SURFACE_THRESHOLD, threshold);
        write_reg(REG_SURFACE_GAIN, CFG_DAT_W'(s_gain));
        write_reg(REG_INTERFLOW_GAIN, CFG_DAT_W'(i_gain));
        write_reg(REG_BASEFLOW_GAIN, CFG_DAT_W'(b_gain));
        write_reg(REG_PERCOLATION_AMOUNT, perc);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_cell(input logic [TAG_W-1:0]   tag,
                             input logic [LEVEL_W-1:0] upper,
                             input logic [LEVEL_W-1:0] lower);
        int gap;
        gap = draw_wait(sender_busy);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lower, upper, tag};
        do @(posedge clk); while (!s_tready);
        cells_sent++;
    endtask

    // registers may only change once every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    initial
    begin : stimulus
        logic [LEVEL_W-1:0] th;
        logic [LEVEL_W-1:0] perc;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at their reset values
        send_cell(16'h0000, 32'h0, 32'h0);
        send_cell(16'hFFFF, LEVEL_MAX, LEVEL_MAX);
        drain();

        // threshold 10 mm, percolation 2 mm
        th   = 32'h000A_0000;
        perc = 32'h0002_0000;
        load_settings(th, 16'h4000, 16'h1000, 16'h0800, perc);
        send_cell(16'h0001, 5 * ONE_MM, 20 * ONE_MM);
        send_cell(16'h0002, th, 20 * ONE_MM);
        send_cell(16'h0003, th + 1, 20 * ONE_MM);
        send_cell(16'h0004, 32'h0, 32'h0);
        send_cell(16'h0005, ONE_MM, 32'h0);
        send_cell(16'h0006, LEVEL_MAX, LEVEL_MAX);
        send_cell(16'h0007, 50 * ONE_MM, LEVEL_MAX - ONE_MM);
        send_cell(16'h1234, 32'h0, 100 * ONE_MM);
        send_cell(16'hABCD, 30 * ONE_MM, 30 * ONE_MM);
        drain();

        // full-scale gains and percolation, no threshold
        load_settings('0, '1, '1, '1, LEVEL_MAX);
        send_cell(16'h00FF, LEVEL_MAX, LEVEL_MAX);
        send_cell(16'hFF00, 32'h1, 32'h1);
        send_cell(16'h5555, 32'h0, LEVEL_MAX);
        send_cell(16'hAAAA, LEVEL_MAX, 32'h0);
        send_cell(16'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom));
        drain();

        // nothing flows and nothing percolates
        load_settings(LEVEL_MAX, '0, '0, '0, '0);
        send_cell(16'h8000, LEVEL_MAX, 32'h0);
        send_cell(16'h7FFF, LEVEL_MAX - 1, 32'h5);
        send_cell(16'h0F0F, 32'h0123_4567, LEVEL_MAX);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            th   = pick_amount();
            perc = pick_amount();
            load_settings(th, pick_gain(), pick_gain(), pick_gain(), perc);
            for (int n = 0; n < CELLS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    sender_busy = ($urandom_range(0, 3) == 0);
                send_cell(16'($urandom), pick_level(th), pick_level(LEVEL_MAX - perc));
            end
            drain();
        end

        repeat (PIPE_DEPTH + 4) @(posedge clk);
        $display("covered %0d cells under %0d register settings, %0d results checked",
                 cells_sent, settings_used, results_checked);
        $display("settings spanned zero and full-scale gains, thresholds and percolation");
        if (fail_count == 0)
            $display("two_reservoir_discharge_step test passed");
        else
            $display("two_reservoir_discharge_step test failed");
        $finish;
    end

    // output side may stall before each result transaction
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            if (taken % 32 == 0)
                sink_busy = ($urandom_range(0, 3) == 0);
            stall = draw_wait(sink_busy);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("two_reservoir_discharge_step test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
